[src/qdd_pkg.sv]
`default_nettype none

package qdd_pkg;

  // Field widths of one frame header.
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned TID_W      = 4;
  localparam int unsigned SEQ_W      = 12;
  localparam int unsigned FRAG_W     = 4;
  localparam int unsigned SF_W       = SEQ_W + FRAG_W;
  localparam int unsigned DATA_KEY_W = ADDR_W + TID_W;

  // Default cache depths.
  localparam int unsigned QDD_DATA_ENTRIES = 32;
  localparam int unsigned QDD_MGMT_ENTRIES = 16;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } qdd_state_t;

  // Control broadcast from a chain to each of its cells.
  typedef struct packed {
    logic cmp_en;    // compare the query against the entry
    logic shift_en;  // insert: every cell takes its left neighbor's entry
    logic upd_en;    // hit update: the hitting cell may rewrite its seq/frag
    logic retry;     // retry bit of the query
  } qdd_cell_ctl_t;

endpackage

`default_nettype wire

[src/wlan_qos_duplicate_frame_detector.sv]
`default_nettype none

// Channel   Handshake            Payload
// input     start / busy         in_transmitter_address, in_traffic_id, in_is_management,
//                                in_retry_bit, in_seq_number, in_frag_number
// result    out_valid (strobe)   out_is_duplicate, out_table_full
//
// An item passes through capture, a parallel compare in every cell of the
// selected cache row, then the update, with the result strobed in the cycle after.
// A new item may be started in the cycle that carries the result strobe.
// Synchronous reset clears all valid bits, so both caches start empty.
// The result is shown for one cycle only; the receiver cannot hold it off.

module wlan_qos_duplicate_frame_detector
  import qdd_pkg::*;
#(
  parameter int unsigned DATA_ENTRIES = QDD_DATA_ENTRIES,
  parameter int unsigned MGMT_ENTRIES = QDD_MGMT_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ADDR_W-1:0] in_transmitter_address,
  input  wire logic [TID_W-1:0]  in_traffic_id,
  input  wire logic              in_is_management,
  input  wire logic              in_retry_bit,
  input  wire logic [SEQ_W-1:0]  in_seq_number,
  input  wire logic [FRAG_W-1:0] in_frag_number,
  output logic                   out_valid,
  output logic                   out_is_duplicate,
  output logic                   out_table_full
);

  qdd_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] q_addr_r;
  logic [TID_W-1:0]  q_tid_r;
  logic              q_mgmt_r;
  logic              q_retry_r;
  logic [SF_W-1:0]   q_sf_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_dup_r, out_dup_nxt;
  logic              out_full_r, out_full_nxt;

  logic accept;
  logic d_cmp, d_upd, m_cmp, m_upd;
  logic d_hit, d_dup, d_full;
  logic m_hit, m_dup, m_full;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Capture the header of an accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_addr_r  <= in_transmitter_address;
      q_tid_r   <= in_traffic_id;
      q_mgmt_r  <= in_is_management;
      q_retry_r <= in_retry_bit;
      q_sf_r    <= {in_seq_number, in_frag_number};
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dup_r  <= out_dup_nxt;
    out_full_r <= out_full_nxt;
  end

  // Sequencer: compare, then update and form the result.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_dup_nxt   = out_dup_r;
    out_full_nxt  = out_full_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (q_mgmt_r) begin
          out_dup_nxt  = m_dup;
          out_full_nxt = !m_hit && m_full;
        end else begin
          out_dup_nxt  = d_dup;
          out_full_nxt = !d_hit && d_full;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign d_cmp = (state_r == ST_CMP) && !q_mgmt_r;
  assign d_upd = (state_r == ST_UPD) && !q_mgmt_r;
  assign m_cmp = (state_r == ST_CMP) && q_mgmt_r;
  assign m_upd = (state_r == ST_UPD) && q_mgmt_r;

  // Data frames: keyed by address and TID.
  qdd_chain #(
    .DEPTH(DATA_ENTRIES),
    .KEY_W(DATA_KEY_W)
  ) u_data_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmp_en (d_cmp),
    .upd_en (d_upd),
    .q_key  ({q_addr_r, q_tid_r}),
    .q_sf   (q_sf_r),
    .q_retry(q_retry_r),
    .any_hit(d_hit),
    .dup    (d_dup),
    .full   (d_full)
  );

  // Management frames: keyed by address alone.
  qdd_chain #(
    .DEPTH(MGMT_ENTRIES),
    .KEY_W(ADDR_W)
  ) u_mgmt_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmp_en (m_cmp),
    .upd_en (m_upd),
    .q_key  (q_addr_r),
    .q_sf   (q_sf_r),
    .q_retry(q_retry_r),
    .any_hit(m_hit),
    .dup    (m_dup),
    .full   (m_full)
  );

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;
  assign out_table_full   = out_full_r;

endmodule

`default_nettype wire

[src/qdd_cell.sv]
`default_nettype none

module qdd_cell
  import qdd_pkg::*;
#(
  parameter int unsigned KEY_W = DATA_KEY_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire qdd_cell_ctl_t    ctl,
  input  wire logic [KEY_W-1:0] q_key,
  input  wire logic [SF_W-1:0]  q_sf,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic [SF_W-1:0]  left_sf,
  input  wire logic             left_valid,
  output logic      [KEY_W-1:0] key,
  output logic      [SF_W-1:0]  sf,
  output logic                  valid,
  output logic                  hit,
  output logic                  same_sf
);

  logic [KEY_W-1:0] key_r;
  logic [SF_W-1:0]  sf_r;
  logic             valid_r;
  logic             hit_r;
  logic             same_r;

  // Entry storage: shifts along the row on insert, rewrites seq/frag on a hit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift_en) begin
      valid_r <= left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      key_r <= left_key;
      sf_r  <= left_sf;
    end else if (ctl.upd_en && hit_r && !(same_r && ctl.retry)) begin
      sf_r <= q_sf;
    end
  end

  // Compare stage: the result is held for the update cycle.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      hit_r  <= valid_r && (key_r == q_key);
      same_r <= (sf_r == q_sf);
    end
  end

  assign key     = key_r;
  assign sf      = sf_r;
  assign valid   = valid_r;
  assign hit     = hit_r;
  assign same_sf = same_r;

endmodule

`default_nettype wire

[src/qdd_chain.sv]
`default_nettype none

module qdd_chain
  import qdd_pkg::*;
#(
  parameter int unsigned DEPTH = QDD_DATA_ENTRIES,
  parameter int unsigned KEY_W = DATA_KEY_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmp_en,
  input  wire logic             upd_en,
  input  wire logic [KEY_W-1:0] q_key,
  input  wire logic [SF_W-1:0]  q_sf,
  input  wire logic             q_retry,
  output logic                  any_hit,
  output logic                  dup,
  output logic                  full
);

  // Neighbor links; position zero is the query itself, entering as a valid entry.
  logic [KEY_W-1:0] key_a   [DEPTH+1];
  logic [SF_W-1:0]  sf_a    [DEPTH+1];
  logic             valid_a [DEPTH+1];
  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] same_vec;
  qdd_cell_ctl_t    ctl;

  assign key_a[0]   = q_key;
  assign sf_a[0]    = q_sf;
  assign valid_a[0] = 1'b1;

  // Entries fill from the head and are never evicted, so the last cell
  // being valid means the row is full.
  assign any_hit = |hit_vec;
  assign dup     = q_retry && (|(hit_vec & same_vec));
  assign full    = valid_a[DEPTH];

  assign ctl.cmp_en   = cmp_en;
  assign ctl.shift_en = upd_en && !any_hit && !full;
  assign ctl.upd_en   = upd_en;
  assign ctl.retry    = q_retry;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qdd_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .q_key     (q_key),
      .q_sf      (q_sf),
      .left_key  (key_a[i]),
      .left_sf   (sf_a[i]),
      .left_valid(valid_a[i]),
      .key       (key_a[i+1]),
      .sf        (sf_a[i+1]),
      .valid     (valid_a[i+1]),
      .hit       (hit_vec[i]),
      .same_sf   (same_vec[i])
    );
  end

endmodule

`default_nettype wire
